[rtl/asd_pkg.sv]
// Shared widths, reset values, register indexes and control types for the step detector.
package asd_pkg;

    localparam int SAMPLE_BITS = 13;

    // Derived datapath widths
    localparam int DIFF_W     = SAMPLE_BITS + 1;
    localparam int ROOT_W     = SAMPLE_BITS + 1;
    localparam int SUM_W      = 2 * ROOT_W;
    localparam int THR_W      = 11;
    localparam int CMP_W      = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
    localparam int MAG_W      = 14;
    localparam int IN_FIELD_W = 3 * SAMPLE_BITS + 1;
    localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((MAG_W + 7) / 8) * 8;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_X_THRESHOLD       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_MARGIN      = 3'd4;

    localparam logic [CFG_DATA_W-1:0] X_THRESHOLD_RST       = 10'd35;
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_FLOOR_RST   = 10'd175;
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_CEILING_RST = 10'd195;
    localparam logic [STEP_W-1:0]     THRESHOLD_STEP_RST    = 4'd2;
    localparam logic [CFG_DATA_W-1:0] RAISE_MARGIN_RST      = 10'd200;
    localparam logic [THR_W-1:0]      YZ_THRESHOLD_RST      = 11'd185;

    // Axis select for the shared squarer; AXIS_NONE drains the product register
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic       load;        // take the input word
        logic       sq_mul;      // square the selected axis difference
        logic       sq_acc;      // add the product register into the sum
        logic [1:0] axis;
        logic       adapt;       // update flags, thresholds, reference
        logic       emit;        // the current word produces a step
        logic       sqrt_start;
        logic       out_load;
    } asd_cmd_t;

    typedef struct packed {
        logic emit_now;
        logic sqrt_busy;
        logic out_free;
    } asd_sts_t;

endpackage

[rtl/asd_isqrt.sv]
// Bit-serial restoring integer square root, one result bit per cycle.
module asd_isqrt
    import asd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] cand;

    assign rem_sh = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign cand   = SH_W'({root_reg, 2'b01});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SUM_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (rem_sh >= cand)
            begin
                rem_next  = REM_W'(rem_sh - cand);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[rtl/asd_datapath.sv]
// Sample storage, configuration registers, squarer, threshold adaptation and output register.
module asd_datapath
    import asd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  asd_cmd_t              cmd,
    output asd_sts_t              sts,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int FLAG_X = 0;
    localparam int FLAG_Y = 1;
    localparam int FLAG_Z = 2;
    localparam int EXT_W  = ROOT_W + MAG_W;

    function automatic logic [SAMPLE_BITS-1:0] mag_of(logic signed [SAMPLE_BITS-1:0] v);
        return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(~v + 1'b1) : SAMPLE_BITS'(v);
    endfunction

    // |(|a| - |b|)|
    function automatic logic [SAMPLE_BITS-1:0] change_of(logic signed [SAMPLE_BITS-1:0] a,
                                                         logic signed [SAMPLE_BITS-1:0] b);
        logic [SAMPLE_BITS:0] d;
        logic [SAMPLE_BITS:0] nd;
        d  = {1'b0, mag_of(a)} - {1'b0, mag_of(b)};
        nd = ~d + 1'b1;
        return d[SAMPLE_BITS] ? nd[SAMPLE_BITS-1:0] : d[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [THR_W-1:0] thr_next(logic [SAMPLE_BITS-1:0] chg,
                                                  logic [THR_W-1:0]       thr,
                                                  logic [CFG_DATA_W-1:0]  lo,
                                                  logic [CFG_DATA_W-1:0]  hi,
                                                  logic [STEP_W-1:0]      inc,
                                                  logic [CFG_DATA_W-1:0]  margin);
        logic [CMP_W-1:0] over;
        logic [THR_W-1:0] t;
        over = CMP_W'(chg) - CMP_W'(thr);
        t    = thr;
        if ((CMP_W'(chg) >= CMP_W'(thr)) && (over > CMP_W'(margin)))
        begin
            if (t > THR_W'(hi))
                t = THR_W'(hi);
            else if (t < THR_W'(lo))
                t = THR_W'(lo);
            if (t < THR_W'(hi))
                t = t + THR_W'(inc);
        end
        return t;
    endfunction

    // Input word fields
    logic signed [SAMPLE_BITS-1:0] in_s [3];
    logic                          in_vib;

    assign in_s[0] = in_data[SAMPLE_BITS-1:0];
    assign in_s[1] = in_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_s[2] = in_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign in_vib  = in_data[3*SAMPLE_BITS];

    // Configuration
    logic [CFG_DATA_W-1:0] x_thr_reg, floor_reg, ceil_reg, margin_reg;
    logic [STEP_W-1:0]     step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_thr_reg  <= X_THRESHOLD_RST;
            floor_reg  <= THRESHOLD_FLOOR_RST;
            ceil_reg   <= THRESHOLD_CEILING_RST;
            step_reg   <= THRESHOLD_STEP_RST;
            margin_reg <= RAISE_MARGIN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_X_THRESHOLD:       x_thr_reg  <= cfg_data;
                CFG_THRESHOLD_FLOOR:   floor_reg  <= cfg_data;
                CFG_THRESHOLD_CEILING: ceil_reg   <= cfg_data;
                CFG_THRESHOLD_STEP:    step_reg   <= cfg_data[STEP_W-1:0];
                CFG_RAISE_MARGIN:      margin_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Detector state
    logic                          started_reg;
    logic [2:0]                    flags_reg;
    logic [THR_W-1:0]              y_thr_reg, z_thr_reg;
    logic signed [SAMPLE_BITS-1:0] ref_reg [3];
    logic signed [SAMPLE_BITS-1:0] cur_reg [3];

    assign sts.emit_now = flags_reg[FLAG_X] & (flags_reg[FLAG_Y] | flags_reg[FLAG_Z]) & ~in_vib;

    // Adaptation: after a step the reference equals the current sample and flags restart
    logic signed [SAMPLE_BITS-1:0] ref_eff [3];
    logic [2:0]                    flags_base;
    logic [SAMPLE_BITS-1:0]        chg_x, chg_y, chg_z;
    logic [2:0]                    flags_new;
    logic [THR_W-1:0]              y_thr_new, z_thr_new;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ref_eff[i] = cmd.emit ? cur_reg[i] : ref_reg[i];
        end
        flags_base = cmd.emit ? 3'b000 : flags_reg;
        chg_x      = change_of(cur_reg[0], ref_eff[0]);
        chg_y      = change_of(cur_reg[1], ref_eff[1]);
        chg_z      = change_of(cur_reg[2], ref_eff[2]);
        flags_new  = flags_base;
        if (CMP_W'(chg_x) >= CMP_W'(x_thr_reg))
            flags_new[FLAG_X] = 1'b1;
        if (CMP_W'(chg_y) >= CMP_W'(y_thr_reg))
            flags_new[FLAG_Y] = 1'b1;
        if (CMP_W'(chg_z) >= CMP_W'(z_thr_reg))
            flags_new[FLAG_Z] = 1'b1;
        y_thr_new = thr_next(chg_y, y_thr_reg, floor_reg, ceil_reg, step_reg, margin_reg);
        z_thr_new = thr_next(chg_z, z_thr_reg, floor_reg, ceil_reg, step_reg, margin_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            flags_reg   <= '0;
            y_thr_reg   <= YZ_THRESHOLD_RST;
            z_thr_reg   <= YZ_THRESHOLD_RST;
            for (int i = 0; i < 3; i++)
            begin
                ref_reg[i] <= '0;
                cur_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (started_reg)
                    cur_reg[i] <= in_s[i];
                else
                    ref_reg[i] <= in_s[i];
            end
        end
        else if (cmd.adapt)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ref_reg[i] <= ref_eff[i];
            end
            if (started_reg)
            begin
                flags_reg <= flags_new;
                y_thr_reg <= y_thr_new;
                z_thr_reg <= z_thr_new;
            end
            else
            begin
                flags_reg   <= flags_base;
                started_reg <= 1'b1;
            end
        end
    end

    // Sum of squares, one axis per cycle through a shared multiplier
    logic signed [SAMPLE_BITS-1:0] sel_cur, sel_ref;
    logic signed [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]             abs_diff;
    logic [SUM_W-1:0]              prod_reg;
    logic [SUM_W-1:0]              acc_reg;

    always_comb
    begin
        case (cmd.axis)
            AXIS_X:
            begin
                sel_cur = cur_reg[0];
                sel_ref = ref_reg[0];
            end
            AXIS_Y:
            begin
                sel_cur = cur_reg[1];
                sel_ref = ref_reg[1];
            end
            AXIS_Z:
            begin
                sel_cur = cur_reg[2];
                sel_ref = ref_reg[2];
            end
            default:
            begin
                sel_cur = '0;
                sel_ref = '0;
            end
        endcase
        diff     = DIFF_W'(sel_cur) - DIFF_W'(sel_ref);
        abs_diff = diff[DIFF_W-1] ? DIFF_W'(~diff + 1'b1) : DIFF_W'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_mul)
            prod_reg <= abs_diff * abs_diff;
        if (cmd.load)
            acc_reg <= '0;
        else if (cmd.sq_acc)
            acc_reg <= acc_reg + prod_reg;
    end

    // Square root
    logic              sqrt_busy;
    logic [ROOT_W-1:0] root;
    logic [EXT_W-1:0]  root_ext;
    logic [MAG_W-1:0]  mag_sat;

    asd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign sts.sqrt_busy = sqrt_busy;
    assign root_ext      = EXT_W'(root);
    assign mag_sat       = (root_ext > EXT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

    // Output register
    logic             out_valid_reg;
    logic [MAG_W-1:0] out_mag_reg;

    assign sts.out_free = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_mag_reg <= mag_sat;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_DATA_W'(out_mag_reg);

endmodule

[rtl/asd_ctrl.sv]
// Sequencer: input acceptance, squaring passes, adaptation, square root and result hand-off.
module asd_ctrl
    import asd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  asd_sts_t sts,
    output asd_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SQ    = 2'd1;
    localparam logic [1:0] ST_ADAPT = 2'd2;
    localparam logic [1:0] ST_ROOT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] sq_cnt_reg, sq_cnt_next;
    logic       emit_reg, emit_next;

    always_comb
    begin
        state_next  = state_reg;
        sq_cnt_next = sq_cnt_reg;
        emit_next   = emit_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.axis    = AXIS_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    emit_next   = sts.emit_now;
                    sq_cnt_next = AXIS_X;
                    state_next  = sts.emit_now ? ST_SQ : ST_ADAPT;
                end
            end
            ST_SQ:
            begin
                // products are registered, so the sum takes each product in the cycle after it is formed
                cmd.axis    = sq_cnt_reg;
                cmd.sq_mul  = (sq_cnt_reg != AXIS_NONE);
                cmd.sq_acc  = (sq_cnt_reg != AXIS_X);
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == AXIS_NONE)
                    state_next = ST_ADAPT;
            end
            ST_ADAPT:
            begin
                cmd.adapt      = 1'b1;
                cmd.emit       = emit_reg;
                cmd.sqrt_start = emit_reg;
                state_next     = emit_reg ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                if (!sts.sqrt_busy && sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sq_cnt_reg <= AXIS_X;
            emit_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sq_cnt_reg <= sq_cnt_next;
            emit_reg   <= emit_next;
        end
    end

endmodule

[rtl/accel_step_detector_unit.sv]
// Top level of the accelerometer step detector: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  s_axis  | in        | s_axis_tvalid/tready  | tdata: accel_x, accel_y, accel_z, vibrated
//  m_axis  | out       | m_axis_tvalid/tready  | tdata: step_magnitude
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  A word with no step is accepted, then adapted. A step word is accepted, passes the
//  shared squarer one axis at a time, is adapted, goes through the one-bit-per-cycle square
//  root, then the result register is loaded.
//  Reset is asynchronous, active low; config and thresholds return to their defaults.
//  A held result stalls only the next step word at its final load; words without a step
//  pass meanwhile. Config writes are taken every cycle.
module accel_step_detector_unit
    import asd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [12:0] accel_x, [25:13] accel_y, [38:26] accel_z, [39] vibrated
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [13:0] step_magnitude, [15:14] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    asd_cmd_t cmd;
    asd_sts_t sts;

    asd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    asd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
